// ===== hdl/sudu_pkg.sv =====
package sudu_pkg;

  // Store geometry
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the transactions
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned RES_W   = 16;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_UNIQUE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Result word, lowest bit first: added, overflow, position, count, padding
  typedef struct packed {
    logic [RES_W-COUNT_W-POS_W-3:0] pad;
    logic [COUNT_W-1:0]             count;
    logic [POS_W-1:0]               position;
    logic                           overflow;
    logic                           added;
  } result_t;

endpackage

// ===== hdl/set_union_dedup_append_unit.sv =====
// Set union store: each input transaction carries a kind in tuser and a 32-bit
// value in tdata, and yields exactly one result transaction (added, overflow,
// position, count). An unconditional append, a clear or an unused kind has its
// result registered at the edge that accepts it. An append-if-absent
// walks the valid entries through the single read port of the store, one entry
// per cycle, and finishes at the first match or after the last valid entry of
// the store, which holds up to 32 entries. A new transaction is taken while the
// previous result still sits in the output register, provided that register
// drains in the same cycle.
module set_union_dedup_append_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] added, [1] overflow, [6:2] position,
                                      // [12:7] count, [15:13] zero
);
  import sudu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   scan_addr_q, scan_addr_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               rd_valid_q, rd_valid_d;
  logic [VALUE_W-1:0] value_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic               out_free;
  logic               in_fire;
  logic               full;
  logic               match;
  logic               miss_end;
  logic               issue;
  logic               mem_we;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [VALUE_W-1:0] mem_rdata;
  result_t            append_res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_q == CNT_W'(CAPACITY));

  // Scan status: registered read data is compared in the cycle after the read
  assign match    = rd_valid_q && (mem_rdata == value_q);
  assign issue    = (scan_addr_q < fill_q);
  assign miss_end = !rd_valid_q && !issue;

  // Result of an append at the current fill level
  always_comb begin
    append_res          = '0;
    append_res.added    = !full;
    append_res.overflow = full;
    append_res.position = full ? '0 : POS_W'(fill_q);
    append_res.count    = full ? COUNT_W'(fill_q) : COUNT_W'(fill_q + 1'b1);
  end

  // Control: accept, scan, append and result load
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    scan_addr_d = scan_addr_q;
    rd_idx_d    = rd_idx_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wdata   = value_q;
    mem_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d       = '0;
          out_d.count = COUNT_W'(fill_q);
          case (s_axis_tuser)
            KIND_APPEND: begin
              out_valid_d = 1'b1;
              out_d       = append_res;
              mem_we      = !full;
              mem_wdata   = s_axis_tdata;
              if (!full) begin
                fill_d = fill_q + 1'b1;
              end
            end
            KIND_UNIQUE: begin
              state_d     = ST_SCAN;
              scan_addr_d = '0;
              rd_valid_d  = 1'b0;
            end
            KIND_CLEAR: begin
              out_valid_d = 1'b1;
              out_d.count = '0;
              fill_d      = '0;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match || miss_end) begin
          // Hold the scan until the output register can take the result
          if (out_free) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
            rd_valid_d  = 1'b0;
            if (match) begin
              out_d          = '0;
              out_d.position = POS_W'(rd_idx_q);
              out_d.count    = COUNT_W'(fill_q);
            end else begin
              out_d  = append_res;
              mem_we = !full;
              if (!full) begin
                fill_d = fill_q + 1'b1;
              end
            end
          end
        end else begin
          mem_re     = issue;
          rd_valid_d = issue;
          rd_idx_d   = scan_addr_q[IDX_W-1:0];
          if (issue) begin
            scan_addr_d = scan_addr_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    rd_idx_q    <= rd_idx_d;
    out_q       <= out_d;
    if (in_fire) begin
      value_q <= s_axis_tdata;
    end
  end

  // Writes land at the fill level only, which a later scan reads no earlier
  // than the following cycle, so no forwarding path is needed
  sudu_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_addr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== hdl/sudu_store.sv =====
module sudu_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [sudu_pkg::IDX_W-1:0]     waddr_i,
  input  logic [sudu_pkg::VALUE_W-1:0]   wdata_i,
  input  logic                           re_i,
  input  logic [sudu_pkg::IDX_W-1:0]     raddr_i,
  output logic [sudu_pkg::VALUE_W-1:0]   rdata_o
);
  import sudu_pkg::*;

  logic [VALUE_W-1:0] mem_q [CAPACITY];
  logic [VALUE_W-1:0] rdata_q;

  // One write port, one read port, registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sudu_checker.sv =====
module sudu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata
);
  import sudu_pkg::*;

  result_t res;
  assign res = m_axis_tdata;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Count never exceeds the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.count <= COUNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // A new entry sits just below the new count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.added |->
      !res.overflow && res.count != '0 && res.position == POS_W'(res.count - 1'b1))
    else $error("added result inconsistent");

  // A dropped value only happens on a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.overflow |->
      res.count == COUNT_W'(CAPACITY) && res.position == '0)
    else $error("overflow without full store");

  // A clear answers on the next cycle with an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CLEAR |=>
      m_axis_tvalid && res.count == '0 && !res.added && !res.overflow)
    else $error("clear result wrong");

endmodule

bind set_union_dedup_append_unit sudu_checker u_sudu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/set_union_scoreboard.sv =====
module set_union_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream, observed only
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic [1:0]  s_tuser_i,   // [1:0] kind
  // Result stream, observed only
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [0] added, [1] overflow, [6:2] position,
                                   // [12:7] count, [15:13] zero
  output int          pending_o,
  output int          checked_o,
  output int          failures_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import sudu_pkg::*;

  localparam int MAX_REPORTS = 200;

  // Shadow copy of the union store
  logic [VALUE_W-1:0] union_store [CAPACITY];
  int                 union_fill;

  result_t            union_results_q [$];
  int                 mismatches;
  int                 checked;

  // Write a value at the tail of the shadow store, or flag it as dropped
  function automatic result_t append_to_store(input logic [VALUE_W-1:0] value);
    result_t r;
    r = '0;
    if (union_fill >= CAPACITY) begin
      r.overflow = 1'b1;
      r.count    = COUNT_W'(union_fill);
    end else begin
      union_store[union_fill] = value;
      r.added    = 1'b1;
      r.position = POS_W'(union_fill);
      union_fill++;
      r.count    = COUNT_W'(union_fill);
    end
    return r;
  endfunction

  // Expected result of one transaction; updates the shadow store
  function automatic result_t predict_union(input logic [KIND_W-1:0] kind,
                                            input logic [VALUE_W-1:0] value);
    result_t r;
    bit      hit;
    r   = '0;
    hit = 1'b0;
    case (kind)
      KIND_APPEND: r = append_to_store(value);
      KIND_UNIQUE: begin
        // lowest matching index wins
        for (int i = 0; i < union_fill; i++) begin
          if (!hit && union_store[i] == value) begin
            hit        = 1'b1;
            r.position = POS_W'(i);
            r.count    = COUNT_W'(union_fill);
          end
        end
        if (!hit) r = append_to_store(value);
      end
      KIND_CLEAR: union_fill = 0;
      default: r.count = COUNT_W'(union_fill);
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Predict on input transactions, compare on result transactions
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      union_fill = 0;
      union_results_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        union_results_q.push_back(predict_union(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (union_results_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result with none expected, expected nothing actual %h",
                     $time, got);
          mismatches++;
        end else begin
          want = union_results_q.pop_front();
          check_field("added",    want.added,    got.added);
          check_field("overflow", want.overflow, got.overflow);
          check_field("position", want.position, got.position);
          check_field("count",    want.count,    got.count);
          check_field("pad",      want.pad,      got.pad);
          checked++;
        end
      end
    end
    pending_o  <= union_results_q.size();
    checked_o  <= checked;
    failures_o <= mismatches + union_results_q.size();
  end

endmodule

// ===== bench/tb_set_union_dedup_append_unit.sv =====
module tb_set_union_dedup_append_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import sudu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_ITEMS     = 800;
  localparam int HOLD_CYCLES   = 200;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int DRAIN_CYCLES  = 40;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] value
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] added, [1] overflow, [6:2] position,
                                     // [12:7] count, [15:13] zero

  int pending;
  int checked;
  int failures;

  bit steady_mode  = 1'b0;   // no idling on either side
  bit hold_off_req = 1'b0;   // requests a single long receiver stall
  int n_items      = 0;      // transactions that are not ignored
  int kind_cnt [4] = '{default: 0};
  int idle_cycles  = 0;

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  set_union_dedup_append_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  set_union_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .pending_o  (pending),
    .checked_o  (checked),
    .failures_o (failures)
  );

  // Watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Result side backpressure
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else
        m_axis_tready <= steady_mode || ($urandom_range(99) >= 30);
    end
  end

  // Offer one transaction, with random gaps in front, and wait for acceptance
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [31:0] value);
    while (!steady_mode && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    kind_cnt[kind]++;
    if (kind != KIND_UNUSED) n_items++;
  endtask

  // Sender pause until every expected result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Copy a first set in, then merge a second set drawn mostly from the same pool
  task automatic union_sequence();
    logic [31:0] pool_base;
    int          pool_size;
    int          n_first;
    int          n_second;
    pool_base = $urandom;
    pool_size = $urandom_range(1, 24);
    n_first   = $urandom_range(0, 16);
    n_second  = $urandom_range(1, 24);
    if ($urandom_range(9) < 8) send_item(KIND_CLEAR, $urandom);
    repeat (n_first)
      send_item(KIND_APPEND, pool_base + $urandom_range(pool_size - 1));
    repeat (n_second)
      send_item(KIND_UNIQUE, ($urandom_range(9) == 0) ? $urandom
                                                      : pool_base + $urandom_range(pool_size - 1));
  endtask

  // Noise: any kind, any value
  task automatic noise_sequence();
    repeat ($urandom_range(1, 8))
      send_item(KIND_W'($urandom_range(3)), $urandom);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [31:0] last_val;
    int          seq;
    seq = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, extremes, duplicates, ignored kind
    send_item(KIND_CLEAR,  32'h0000_0000);
    send_item(KIND_UNIQUE, 32'h0000_0000);
    send_item(KIND_APPEND, 32'h7FFF_FFFF);
    send_item(KIND_APPEND, 32'h8000_0000);
    send_item(KIND_APPEND, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'h0000_0000);
    send_item(KIND_UNIQUE, 32'h8000_0000);
    send_item(KIND_UNIQUE, 32'h0000_0000);
    send_item(KIND_UNIQUE, 32'hFFFF_FFFF);
    send_item(KIND_UNIQUE, 32'h0000_0001);
    send_item(KIND_UNUSED, 32'hAAAA_AAAA);
    send_item(KIND_UNUSED, 32'h5555_5555);
    send_item(KIND_CLEAR,  32'hFFFF_FFFF);
    send_item(KIND_UNIQUE, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 32'h0000_0000);
    wait_drained();

    // Full store: drop on both append kinds, match at the last index
    send_item(KIND_CLEAR, $urandom);
    last_val = '0;
    repeat (CAPACITY) begin
      last_val = {1'b0, 31'($urandom)};
      send_item(KIND_APPEND, last_val);
    end
    send_item(KIND_APPEND, $urandom);
    send_item(KIND_UNIQUE, {1'b1, 31'($urandom)});
    send_item(KIND_UNIQUE, last_val);
    send_item(KIND_UNUSED, $urandom);

    // Random union sequences with some noise
    while (n_items < NUM_ITEMS) begin
      seq++;
      steady_mode = (seq >= 8 && seq < 16);
      if (seq == 10) hold_off_req = 1'b1;
      if (seq == 20) wait_drained();
      if ($urandom_range(9) < 7) union_sequence();
      else noise_sequence();
    end
    steady_mode = 1'b0;

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d appends, %0d append-if-absent, %0d clears, %0d ignored kinds",
             kind_cnt[KIND_APPEND], kind_cnt[KIND_UNIQUE], kind_cnt[KIND_CLEAR],
             kind_cnt[KIND_UNUSED]);
    $display("Checked %0d results, incl. full-store drops and a %0d-cycle output stall",
             checked, HOLD_CYCLES);
    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
